// ----- src/wrs_pkg.sv -----
// Shared types and constants for the weighted random selector.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package wrs_pkg;

  // Table geometry.
  localparam int MAX_ENTRIES = 256;
  localparam int WEIGHT_BITS = 16;
  localparam int IdxW        = $clog2(MAX_ENTRIES);
  localparam int CntW        = $clog2(MAX_ENTRIES + 1);
  localparam int SumW        = WEIGHT_BITS + IdxW;

  // Field widths of the channel words.
  localparam int ReqW    = 2;
  localparam int WeightW = 16;
  localparam int RandW   = 32;
  localparam int StatusW = 2;

  // Request codes.
  localparam logic [ReqW-1:0] REQ_CLEAR = 2'd0;
  localparam logic [ReqW-1:0] REQ_ADD   = 2'd1;
  localparam logic [ReqW-1:0] REQ_DRAW  = 2'd2;

  // Status codes.
  localparam logic [StatusW-1:0] STAT_OK    = 2'd0;
  localparam logic [StatusW-1:0] STAT_FULL  = 2'd1;
  localparam logic [StatusW-1:0] STAT_EMPTY = 2'd2;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic            shift;
    logic [SumW-1:0] target;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- src/weighted_random_selector.sv -----
// Weighted random selector: table of cumulative weights held in a chain of cells.
// Depends on wrs_pkg, wrs_cell and wrs_search.
//
// Usage: one input word per request (clear, add a weight, draw one entry) on a
// valid/ready channel; exactly one result word per request on the output channel.
// An input word is taken only while the controller is idle; the next word can be
// taken while the previous result still waits in the output register.
// Steps: clear, add and unused request codes execute and then load the output
// register. A draw runs the 32 by 24 bit scaling multiply, the parallel compare
// in all cells, one search step per count bit in the search unit, the hand-back
// of the search result and the load of the output register.
// A new request is taken only after the previous one has loaded its result into
// the output register.
// Reset empties the table (entry count and total go to zero) and drops any
// pending result; the cell contents are only read below the entry count.
// When the receiver stalls, the finished result holds in the output register,
// one further request may be accepted and worked on, and it then waits until
// the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module weighted_random_selector
  import wrs_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [ReqW-1:0]    req_type_i,
  input  wire logic [WeightW-1:0] weight_i,
  input  wire logic [RandW-1:0]   rand_fraction_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [StatusW-1:0] status_o,
  output logic      [IdxW-1:0]    selected_index_o,
  output logic      [CntW-1:0]    entry_count_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [WeightW-1:0] WeightMask = WeightW'((64'd1 << WEIGHT_BITS) - 64'd1);
  localparam int                 ProdW      = RandW + SumW;

  logic [2:0]         state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [SumW-1:0]    total_q, total_d;
  logic               out_valid_q, out_valid_d;
  logic [ReqW-1:0]    req_q;
  logic [WeightW-1:0] weight_q;
  logic [RandW-1:0]   rand_q;
  logic [SumW-1:0]    target_q, target_d;
  logic [StatusW-1:0] stat_q, stat_d;
  logic [IdxW-1:0]    sel_q, sel_d;
  logic [StatusW-1:0] res_status_q;
  logic [IdxW-1:0]    res_index_q;
  logic [CntW-1:0]    res_count_q;
  logic               load_out;
  logic               accept;
  logic               search_start;
  logic               search_done;
  logic [CntW-1:0]    search_ones;
  logic [SumW-1:0]    new_total;
  logic [ProdW-1:0]   product;
  cell_ctrl_t         ctrl;

  logic [SumW-1:0]        sums [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] above_raw;
  logic [MAX_ENTRIES-1:0] above;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = state_q == S_IDLE;
  assign new_total  = total_q + SumW'(weight_q & WeightMask);
  assign product    = ProdW'(rand_q) * ProdW'(total_q);

  // Chain of cells; cell zero takes the new running total on an add.
  for (genvar j = 0; j < MAX_ENTRIES; j++) begin : g_cell
    logic [SumW-1:0] prev_sum;
    if (j == 0) begin : g_head
      assign prev_sum = new_total;
    end else begin : g_body
      assign prev_sum = sums[j-1];
    end
    wrs_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .prev_sum_i (prev_sum),
      .sum_o      (sums[j]),
      .above_o    (above_raw[j])
    );
    // Only the cells below the entry count hold live entries.
    assign above[j] = above_raw[j] && (CntW'(j) < count_q);
  end

  wrs_search u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (search_start),
    .above_i (above),
    .done_o  (search_done),
    .ones_o  (search_ones)
  );

  // Request sequencer.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    total_d      = total_q;
    target_d     = target_q;
    stat_d       = stat_q;
    sel_d        = sel_q;
    ctrl.shift   = 1'b0;
    ctrl.target  = target_q;
    search_start = 1'b0;
    load_out     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        stat_d  = STAT_OK;
        sel_d   = '0;
        state_d = S_DONE;
        case (req_q)
          REQ_CLEAR: begin
            count_d = '0;
            total_d = '0;
          end
          REQ_ADD: begin
            if (count_q >= CntW'(MAX_ENTRIES)) begin
              stat_d = STAT_FULL;
            end else begin
              ctrl.shift = 1'b1;
              total_d    = new_total;
              count_d    = count_q + CntW'(1);
            end
          end
          REQ_DRAW: begin
            if (count_q == '0 || total_q == '0) begin
              stat_d = STAT_EMPTY;
            end else begin
              target_d = product[ProdW-1:RandW];
              state_d  = S_CMP;
            end
          end
          default: begin
          end
        endcase
      end
      S_CMP: begin
        search_start = 1'b1;
        state_d      = S_SRCH;
      end
      S_SRCH: begin
        // Cells hold the newest entry first, so the entry index counts back from the top.
        if (search_done) begin
          sel_d   = IdxW'(count_q - search_ones);
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request word, working values and result word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q    <= req_type_i;
      weight_q <= weight_i;
      rand_q   <= rand_fraction_i;
    end
    target_q <= target_d;
    stat_q   <= stat_d;
    sel_q    <= sel_d;
    if (load_out) begin
      res_status_q <= stat_q;
      res_index_q  <= sel_q;
      res_count_q  <= count_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = res_status_q;
  assign selected_index_o = res_index_q;
  assign entry_count_o    = res_count_q;

endmodule

`default_nettype wire

// ----- src/wrs_cell.sv -----
// One cell of the cumulative sum chain: holds one running sum.
// Depends on wrs_pkg for widths and the control struct.
`timescale 1ns / 1ps
`default_nettype none

module wrs_cell
  import wrs_pkg::*;
(
  input  wire logic            clk_i,
  input  wire cell_ctrl_t      ctrl_i,
  input  wire logic [SumW-1:0] prev_sum_i,
  output logic      [SumW-1:0] sum_o,
  output logic                 above_o
);

  logic [SumW-1:0] sum_q;

  // On an add every cell takes its neighbor's sum, so the newest entry sits in cell zero.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      sum_q <= prev_sum_i;
    end
  end

  // The cell reports whether its sum lies strictly above the draw target.
  assign above_o = sum_q > ctrl_i.target;
  assign sum_o   = sum_q;

endmodule

`default_nettype wire

// ----- src/wrs_search.sv -----
// Bit-serial search for the edge of the thermometer code formed by the cells.
// Depends on wrs_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module wrs_search
  import wrs_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [MAX_ENTRIES-1:0] above_i,
  output logic                        done_o,
  output logic      [CntW-1:0]        ones_o
);

  logic [MAX_ENTRIES-1:0] above_q;
  logic [CntW-1:0]        prefix_q, prefix_d;
  logic [CntW-1:0]        mask_q, mask_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CntW-1:0]        cand;
  logic [CntW-1:0]        cand_m1;
  logic                   in_range;
  logic                   hit;

  // Try to set the current result bit: the candidate holds if the bit just below it is set.
  always_comb begin
    cand     = prefix_q | mask_q;
    cand_m1  = cand - CntW'(1);
    in_range = cand <= CntW'(MAX_ENTRIES);
    hit      = in_range && above_q[cand_m1[IdxW-1:0]];
  end

  // One result bit per cycle, most significant first.
  always_comb begin
    prefix_d = prefix_q;
    mask_d   = mask_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (start_i) begin
      prefix_d = '0;
      mask_d   = CntW'(1) << (CntW - 1);
      busy_d   = 1'b1;
    end else if (busy_q) begin
      if (hit) begin
        prefix_d = cand;
      end
      mask_d = mask_q >> 1;
      if (mask_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Snapshot of the compare vector and the search registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      above_q <= above_i;
    end
    prefix_q <= prefix_d;
    mask_q   <= mask_d;
  end

  assign done_o = done_q;
  assign ones_o = prefix_q;

endmodule

`default_nettype wire
